// ----- hw/rtl/tleg_pkg.sv -----
// ----------------------------------------------------------------------------
// Triangular lattice edge generator package
// Shared widths, register and request codes, and the control and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package tleg_pkg;

    localparam int MAX_ROWS    = 1024;
    localparam int MAX_ROW_LEN = 1024;

    localparam int ROW_W   = $clog2(MAX_ROWS);        // row number
    localparam int POS_W   = $clog2(MAX_ROW_LEN);     // position within a row
    localparam int LEN_W   = 11;                      // row length
    localparam int COORD_W = 11;                      // leftmost coordinate
    localparam int BASE_W  = 21;                      // prefix sum of lengths
    localparam int VTX_W   = 20;                      // vertex index
    localparam int K_W     = COORD_W + 1;             // lattice coordinate
    localparam int CNT_W   = 11;                      // rows_in_use register
    localparam int PROD_W  = CNT_W + LEN_W;           // lex product width

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam int ENTRY_W = LEN_W + COORD_W + BASE_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIRECTED = 2'd0,
        CFG_MUTUAL   = 2'd1,
        CFG_LEX      = 2'd2,
        CFG_ROWS     = 2'd3
    } cfg_idx_t;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_ENUM = 1'b1;

    // Candidate neighbors, in emission order.
    localparam logic [1:0] EDGE_RIGHT   = 2'd0;
    localparam logic [1:0] EDGE_UP      = 2'd1;
    localparam logic [1:0] EDGE_UP_LEFT = 2'd2;

    typedef struct packed {
        logic       accept;     // input transaction taken this cycle
        logic       row_latch;  // row table data of the vertex's row is present
        logic       nbr_latch;  // row table data of the row above is present
        logic       calc;       // compute the selected neighbor's index
        logic       out_load;   // load the result register
        logic       out_rev;    // load the reversed edge
        logic [1:0] edge_sel;   // selected candidate neighbor
    } cmd_t;

    typedef struct packed {
        logic req_enum;   // incoming request is an enumeration
        logic row_valid;  // incoming row is inside the lattice
        logic vertex_ok;  // vertex position is inside its row
        logic nbr_any;    // at least one neighbor exists
        logic exist_sel;  // selected neighbor exists
        logic later;      // a neighbor after the selected one exists
        logic dual;       // each edge is followed by its reverse
    } sts_t;

endpackage

`default_nettype wire

// ----- hw/rtl/tleg_req_if.sv -----
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying row loads and vertex enumeration requests.
// ----------------------------------------------------------------------------
`default_nettype none

interface tleg_req_if;
    import tleg_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 req_type;
    logic [ROW_W-1:0]     row_number;
    logic [LEN_W-1:0]     row_len;
    logic [COORD_W-1:0]   row_first;
    logic [POS_W-1:0]     vertex_pos;

    modport source (
        output valid, req_type, row_number, row_len, row_first, vertex_pos,
        input  ready
    );

    modport sink (
        input  valid, req_type, row_number, row_len, row_first, vertex_pos,
        output ready
    );

endinterface

`default_nettype wire

// ----- hw/rtl/tleg_rsp_if.sv -----
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one lattice edge per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface tleg_rsp_if;
    import tleg_pkg::*;

    logic             valid;
    logic             ready;
    logic [VTX_W-1:0] from_vertex;
    logic [VTX_W-1:0] to_vertex;
    logic             last_edge;

    modport source (
        output valid, from_vertex, to_vertex, last_edge,
        input  ready
    );

    modport sink (
        input  valid, from_vertex, to_vertex, last_edge,
        output ready
    );

endinterface

`default_nettype wire

// ----- hw/rtl/tleg_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tleg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- hw/rtl/tleg_ctrl.sv -----
// ----------------------------------------------------------------------------
// Edge generator controller
// Sequences table reads, neighbor index calculation and result delivery.
// ----------------------------------------------------------------------------
`default_nettype none

module tleg_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  wire logic           out_ready,
    input  wire tleg_pkg::sts_t sts,
    output tleg_pkg::cmd_t      cmd
);
    import tleg_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROW,
        S_NBR,
        S_CALC,
        S_FWD,
        S_REV
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] edge_reg, edge_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept;
    logic       out_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        cmd          = '0;
        cmd.accept   = accept;
        cmd.edge_sel = edge_reg;
        state_next   = state_reg;
        edge_next    = edge_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && sts.req_enum && sts.row_valid)
                begin
                    state_next = S_ROW;
                end
            end
            S_ROW:
            begin
                cmd.row_latch = 1'b1;
                state_next    = sts.vertex_ok ? S_NBR : S_IDLE;
            end
            S_NBR:
            begin
                cmd.nbr_latch = 1'b1;
                edge_next     = EDGE_RIGHT;
                state_next    = sts.nbr_any ? S_CALC : S_IDLE;
            end
            S_CALC:
            begin
                if (sts.exist_sel)
                begin
                    cmd.calc   = 1'b1;
                    state_next = S_FWD;
                end
                else
                begin
                    edge_next = edge_reg + 2'd1;
                end
            end
            S_FWD:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (sts.dual)
                    begin
                        state_next = S_REV;
                    end
                    else if (sts.later)
                    begin
                        edge_next  = edge_reg + 2'd1;
                        state_next = S_CALC;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_REV:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_rev  = 1'b1;
                    if (sts.later)
                    begin
                        edge_next  = edge_reg + 2'd1;
                        state_next = S_CALC;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            edge_reg      <= EDGE_RIGHT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            edge_reg      <= edge_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/tleg_dp.sv -----
// ----------------------------------------------------------------------------
// Edge generator datapath
// Configuration registers, row table, prefix sum, index arithmetic and the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tleg_dp (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_write_en,
    input  wire logic [tleg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [tleg_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic                                req_type,
    input  wire logic [tleg_pkg::ROW_W-1:0]          row_number,
    input  wire logic [tleg_pkg::LEN_W-1:0]          row_len,
    input  wire logic [tleg_pkg::COORD_W-1:0]        row_first,
    input  wire logic [tleg_pkg::POS_W-1:0]          vertex_pos,
    input  wire tleg_pkg::cmd_t                      cmd,
    output tleg_pkg::sts_t                           sts,
    output logic [tleg_pkg::VTX_W-1:0]               from_vertex,
    output logic [tleg_pkg::VTX_W-1:0]               to_vertex,
    output logic                                     last_edge
);
    import tleg_pkg::*;

    // Configuration and prefix sum.
    logic               directed_reg;
    logic               mutual_reg;
    logic               lex_reg;
    logic [CNT_W-1:0]   rows_reg;
    logic [BASE_W-1:0]  total_reg, total_next;

    // Request and row data.
    logic [ROW_W-1:0]   row_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [LEN_W-1:0]   len_j_reg;
    logic [BASE_W-1:0]  base_j_reg;
    logic [K_W-1:0]     k_reg;
    logic [COORD_W-1:0] first_n_reg;
    logic [BASE_W-1:0]  base_n_reg;
    logic [2:0]         exist_reg;
    logic [VTX_W-1:0]   self_reg;
    logic [VTX_W-1:0]   other_reg;
    logic [VTX_W-1:0]   from_reg;
    logic [VTX_W-1:0]   to_reg;
    logic               last_reg;

    // Row table.
    logic               ram_we;
    logic [ROW_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;
    logic [LEN_W-1:0]   rd_len;
    logic [COORD_W-1:0] rd_first;
    logic [BASE_W-1:0]  rd_base;
    logic [LEN_W-1:0]   len_sat;
    logic [BASE_W-1:0]  base_in;

    // Neighbor checks and index arithmetic.
    logic [CNT_W-1:0]   nrow;
    logic               nrow_ok;
    logic [K_W-1:0]     first_n_ext;
    logic [K_W-1:0]     end_n;
    logic [2:0]         exist_now;
    logic [K_W-1:0]     k_off_up;
    logic [K_W-1:0]     k_off_upleft;
    logic [LEN_W-1:0]   off_sel;
    logic [CNT_W-1:0]   row_sel;
    logic [BASE_W-1:0]  base_sel;
    logic [LEN_W-1:0]   mul_off;
    logic [CNT_W-1:0]   mul_row;
    logic [BASE_W-1:0]  mul_base;
    logic [PROD_W-1:0]  prod;
    logic [PROD_W:0]    lex_sum;
    logic [BASE_W-1:0]  rm_sum;
    logic [VTX_W-1:0]   index;
    logic               last_now;

    // ------------------------------------------------------------------
    // Loads and the prefix sum.
    // ------------------------------------------------------------------
    assign len_sat   = (row_len > LEN_W'(MAX_ROW_LEN)) ? LEN_W'(MAX_ROW_LEN) : row_len;
    assign base_in   = (row_number == '0) ? '0 : total_reg;
    assign ram_we    = cmd.accept && (req_type == REQ_LOAD);
    assign ram_wdata = {len_sat, row_first, base_in};
    assign ram_raddr = cmd.accept ? row_number : row_reg + ROW_W'(1);
    assign total_next = base_in + BASE_W'(len_sat);

    tleg_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_ROWS)
    ) u_row_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (row_number),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign {rd_len, rd_first, rd_base} = ram_rdata;

    // ------------------------------------------------------------------
    // Existence of the vertex and of its neighbors.
    // ------------------------------------------------------------------
    assign nrow        = CNT_W'(row_reg) + CNT_W'(1);
    assign nrow_ok     = (nrow < rows_reg) && (nrow < CNT_W'(MAX_ROWS));
    assign first_n_ext = K_W'(rd_first);
    assign end_n       = K_W'(rd_first) + K_W'(rd_len);

    assign exist_now[EDGE_RIGHT]   = (LEN_W'(pos_reg) + LEN_W'(1)) < len_j_reg;
    assign exist_now[EDGE_UP]      = nrow_ok && (k_reg >= first_n_ext) && (k_reg < end_n);
    assign exist_now[EDGE_UP_LEFT] = nrow_ok && (k_reg > first_n_ext) && (k_reg <= end_n);

    // ------------------------------------------------------------------
    // Vertex index: one shared multiplier serves the vertex itself and
    // each neighbor in turn.
    // ------------------------------------------------------------------
    assign k_off_up     = k_reg - K_W'(first_n_reg);
    assign k_off_upleft = k_off_up - K_W'(1);

    always_comb
    begin
        unique case (cmd.edge_sel)
            EDGE_RIGHT:
            begin
                off_sel  = LEN_W'(pos_reg) + LEN_W'(1);
                row_sel  = CNT_W'(row_reg);
                base_sel = base_j_reg;
            end
            EDGE_UP:
            begin
                off_sel  = k_off_up[LEN_W-1:0];
                row_sel  = nrow;
                base_sel = base_n_reg;
            end
            EDGE_UP_LEFT:
            begin
                off_sel  = k_off_upleft[LEN_W-1:0];
                row_sel  = nrow;
                base_sel = base_n_reg;
            end
            default:
            begin
                off_sel  = '0;
                row_sel  = '0;
                base_sel = '0;
            end
        endcase
    end

    assign mul_off  = cmd.row_latch ? LEN_W'(pos_reg) : off_sel;
    assign mul_row  = cmd.row_latch ? CNT_W'(row_reg) : row_sel;
    assign mul_base = cmd.row_latch ? rd_base : base_sel;
    assign prod     = PROD_W'(rows_reg) * PROD_W'(mul_off);
    assign lex_sum  = (PROD_W+1)'(prod) + (PROD_W+1)'(mul_row);
    assign rm_sum   = mul_base + BASE_W'(mul_off);
    assign index    = lex_reg ? lex_sum[VTX_W-1:0] : rm_sum[VTX_W-1:0];

    // ------------------------------------------------------------------
    // Status toward the controller.
    // ------------------------------------------------------------------
    always_comb
    begin
        sts           = '0;
        sts.req_enum  = (req_type == REQ_ENUM);
        sts.row_valid = (CNT_W'(row_number) < rows_reg);
        sts.vertex_ok = (LEN_W'(pos_reg) < rd_len);
        sts.nbr_any   = |exist_now;
        sts.dual      = directed_reg && mutual_reg;
        unique case (cmd.edge_sel)
            EDGE_RIGHT:
            begin
                sts.exist_sel = exist_reg[EDGE_RIGHT];
                sts.later     = exist_reg[EDGE_UP] || exist_reg[EDGE_UP_LEFT];
            end
            EDGE_UP:
            begin
                sts.exist_sel = exist_reg[EDGE_UP];
                sts.later     = exist_reg[EDGE_UP_LEFT];
            end
            EDGE_UP_LEFT:
            begin
                sts.exist_sel = exist_reg[EDGE_UP_LEFT];
                sts.later     = 1'b0;
            end
            default:
            begin
                sts.exist_sel = 1'b0;
                sts.later     = 1'b0;
            end
        endcase
    end

    // The forward half of a mutual pair is never the last result.
    assign last_now = cmd.out_rev ? !sts.later : (!sts.dual && !sts.later);

    // ------------------------------------------------------------------
    // Control registers.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            directed_reg <= 1'b0;
            mutual_reg   <= 1'b0;
            lex_reg      <= 1'b0;
            rows_reg     <= '0;
            total_reg    <= '0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_DIRECTED: directed_reg <= cfg_data[0];
                    CFG_MUTUAL:   mutual_reg   <= cfg_data[0];
                    CFG_LEX:      lex_reg      <= cfg_data[0];
                    CFG_ROWS:     rows_reg     <= cfg_data[CNT_W-1:0];
                endcase
            end
            if (ram_we)
            begin
                total_reg <= total_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers.
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            row_reg <= row_number;
            pos_reg <= vertex_pos;
        end
        if (cmd.row_latch)
        begin
            len_j_reg  <= rd_len;
            base_j_reg <= rd_base;
            k_reg      <= K_W'(rd_first) + K_W'(pos_reg);
            self_reg   <= index;
        end
        if (cmd.nbr_latch)
        begin
            first_n_reg <= rd_first;
            base_n_reg  <= rd_base;
            exist_reg   <= exist_now;
        end
        if (cmd.calc)
        begin
            other_reg <= index;
        end
        if (cmd.out_load)
        begin
            from_reg <= cmd.out_rev ? other_reg : self_reg;
            to_reg   <= cmd.out_rev ? self_reg : other_reg;
            last_reg <= last_now;
        end
    end

    assign from_vertex = from_reg;
    assign to_vertex   = to_reg;
    assign last_edge   = last_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/triangular_lattice_edge_generator_unit.sv -----
// ----------------------------------------------------------------------------
// Triangular lattice edge generator
// Loads row descriptors and lists the edges of one lattice vertex per request.
// ----------------------------------------------------------------------------
// The block works on one request at a time. A row load is taken while idle: the
// row's length (saturated to the maximum row length), its leftmost coordinate
// and the running prefix sum of lengths are written to the row table, and the
// block is ready again in the next cycle; a load of row 0 restarts the sum.
// An enumeration request reads the vertex's row, then the row above, and then,
// for each candidate neighbor (right, up, up-left) up to the last existing one,
// computes the index of that neighbor if it exists and emits one result for it
// (followed by its reverse when directed and mutual are both set); each result
// waits until the output register is free. A request ends on acceptance when
// its row lies outside the lattice, after the read of its row when the position
// lies past the end of that row, and after the read of the row above when the
// vertex has no neighbors. The row table has a single read port and the index
// multiplier is shared. Results leave through an output register, so a new
// request is taken as soon as the last result of the previous one is loaded
// into it, even while that transaction still waits on the response side.
// Configuration writes must be made while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module triangular_lattice_edge_generator_unit (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_write_en,
    input  wire logic [tleg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [tleg_pkg::CFG_DATA_W-1:0] cfg_data,
    tleg_req_if.sink                             request,
    tleg_rsp_if.source                           response
);
    import tleg_pkg::*;

    // Command and status bundles between the controller and the datapath.
    cmd_t cmd;
    sts_t sts;

    // Handshake wires; the controller owns both sides of the flow control.
    logic in_ready;
    logic out_valid;

    assign request.ready  = in_ready;
    assign response.valid = out_valid;

    // The controller sequences row reads, neighbor index calculation and
    // result delivery, and holds the response valid flag.
    tleg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (request.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (response.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // The datapath holds the configuration, the row table, the prefix sum
    // and the result register that drives the response payload.
    tleg_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .req_type     (request.req_type),
        .row_number   (request.row_number),
        .row_len      (request.row_len),
        .row_first    (request.row_first),
        .vertex_pos   (request.vertex_pos),
        .cmd          (cmd),
        .sts          (sts),
        .from_vertex  (response.from_vertex),
        .to_vertex    (response.to_vertex),
        .last_edge    (response.last_edge)
    );

endmodule

`default_nettype wire
